>>> hdl/bis_pkg.sv
// package for the bilinear image scaler: beat types, register map and the
// fixed-point interpolation helper; no dependencies
`default_nettype none

package bis_pkg;

  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int FracBits     = 12;
  localparam int PaddrW       = 4;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_STEP       = 2'd2
  } reg_idx_e;

  localparam logic [8:0]  SrcWidthRst  = 9'd256;
  localparam logic [8:0]  SrcHeightRst = 9'd256;
  localparam logic [15:0] StepRst      = 16'd4096;

  typedef struct packed {
    cmd_e        command;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0]  pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       clamped;
  } out_item_t;

  // a + floor(w * (b - a) / 4096), equal to (a*(4096-w) + b*w) >> 12
  function automatic logic [7:0] lerp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [FracBits-1:0] w);
    logic signed [8:0]  diff;
    logic signed [21:0] prod;
    logic signed [9:0]  delta;
    logic signed [9:0]  sum;
    diff  = $signed({1'b0, b}) - $signed({1'b0, a});
    prod  = $signed({1'b0, w}) * diff;
    delta = 10'(prod >>> FracBits);
    sum   = $signed({2'b00, a}) + delta;
    return sum[7:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/bilinear_image_scaler_core.sv
// bilinear greyscale scaler: 2x2 parity-banked frame store and a
// five-stage sample pipeline; depends on bis_pkg
//
// usage: input beats carry a command. a load beat writes pixel_in into the
// frame store at (pos_x, pos_y); loads outside the store are dropped and give
// no output beat. a sample beat maps (pos_x, pos_y) through the step register
// (Q4.12) to a source position, reads the four neighbours and returns one
// output beat with the interpolated pixel and the clamp flag.
// throughput: one input beat per cycle while the output is not stalled. the
// store is split into four banks by row and column parity, so the four
// neighbours are read together, and loads write in the same pipeline stage
// where samples read, so a sample always sees every earlier load.
// the configuration port (psel/penable/pwrite/paddr/pwdata) is to be written
// by the user only while the pipeline is empty; the block does not enforce
// this. reset sets width and height to 256 and step to 1.0; the store
// contents stay undefined until loaded. when the receiver holds out_ready_i
// low with a result waiting, the whole pipeline stalls and in_ready_o drops
// until that result is taken.
`default_nettype none

module bilinear_image_scaler_core #(
  parameter int MAX_WIDTH  = bis_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bis_pkg::MaxHeightDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire bis_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output bis_pkg::out_item_t              out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [bis_pkg::PaddrW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int BankW  = (MAX_WIDTH + 1) / 2;
  localparam int BankH  = (MAX_HEIGHT + 1) / 2;
  localparam int CW     = (BankW > 1) ? $clog2(BankW) : 1;
  localparam int RW     = (BankH > 1) ? $clog2(BankH) : 1;
  localparam int BankD  = BankW * BankH;
  localparam int AW     = (BankD > 1) ? $clog2(BankD) : 1;
  localparam int FB     = bis_pkg::FracBits;

  // configuration registers
  logic [8:0]  src_width_q, src_height_q;
  logic [15:0] step_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bis_pkg::SrcWidthRst;
      src_height_q <= bis_pkg::SrcHeightRst;
      step_q       <= bis_pkg::StepRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        bis_pkg::REG_SRC_WIDTH:  src_width_q  <= pwdata[8:0];
        bis_pkg::REG_SRC_HEIGHT: src_height_q <= pwdata[8:0];
        bis_pkg::REG_STEP:       step_q       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bis_pkg::REG_SRC_WIDTH:  prdata = {23'd0, src_width_q};
      bis_pkg::REG_SRC_HEIGHT: prdata = {23'd0, src_height_q};
      bis_pkg::REG_STEP:       prdata = {16'd0, step_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // effective last column and row
  logic [12:0]   w_lim, h_lim;
  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;

  always_comb begin
    if (src_width_q == 9'd0) begin
      w_lim = 13'd1;
    end else if ({4'd0, src_width_q} > 13'(MAX_WIDTH)) begin
      w_lim = 13'(MAX_WIDTH);
    end else begin
      w_lim = {4'd0, src_width_q};
    end
    if (src_height_q == 9'd0) begin
      h_lim = 13'd1;
    end else if ({4'd0, src_height_q} > 13'(MAX_HEIGHT)) begin
      h_lim = 13'(MAX_HEIGHT);
    end else begin
      h_lim = {4'd0, src_height_q};
    end
  end

  assign last_x = XW'(w_lim - 13'd1);
  assign last_y = YW'(h_lim - 13'd1);

  // global advance: the pipeline moves whenever the output register frees up
  logic advance;
  logic out_valid_q;
  bis_pkg::out_item_t out_data_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // stage 1: coordinate times step
  logic              s1_v_q;
  bis_pkg::cmd_e     s1_cmd_q;
  logic [11:0]       s1_x_q, s1_y_q;
  logic [7:0]        s1_pix_q;
  logic [27:0]       s1_px_q, s1_py_q;
  logic              s1_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cmd_q <= in_data_i.command;
      s1_x_q   <= in_data_i.pos_x;
      s1_y_q   <= in_data_i.pos_y;
      s1_pix_q <= in_data_i.pixel_in;
      s1_px_q  <= 28'(in_data_i.pos_x) * 28'(step_q);
      s1_py_q  <= 28'(in_data_i.pos_y) * 28'(step_q);
      s1_ok_q  <= ({1'b0, in_data_i.pos_x} < 13'(MAX_WIDTH)) &&
                  ({1'b0, in_data_i.pos_y} < 13'(MAX_HEIGHT));
    end
  end

  // stage 2: clamp and split into bank columns and rows
  logic [15:0]   idx_x, idx_y;
  logic          clip_x, clip_y;
  logic [XW-1:0] x0;
  logic [YW-1:0] y0;
  logic [CW-1:0] col_e_d, col_o_d;
  logic [RW-1:0] row_e_d, row_o_d;

  assign idx_x  = s1_px_q[27:FB];
  assign idx_y  = s1_py_q[27:FB];
  assign clip_x = idx_x > 16'(last_x);
  assign clip_y = idx_y > 16'(last_y);
  assign x0     = clip_x ? last_x : XW'(idx_x);
  assign y0     = clip_y ? last_y : YW'(idx_y);

  always_comb begin
    if (s1_cmd_q == bis_pkg::CMD_LOAD) begin
      col_e_d = CW'(s1_x_q >> 1);
      col_o_d = CW'(s1_x_q >> 1);
      row_e_d = RW'(s1_y_q >> 1);
      row_o_d = RW'(s1_y_q >> 1);
    end else begin
      // an odd left column takes its right neighbour from the next even slot
      col_e_d = CW'((13'(x0) + 13'(x0[0])) >> 1);
      col_o_d = CW'(13'(x0) >> 1);
      row_e_d = RW'((13'(y0) + 13'(y0[0])) >> 1);
      row_o_d = RW'(13'(y0) >> 1);
    end
  end

  logic          s2_v_q;
  bis_pkg::cmd_e s2_cmd_q;
  logic          s2_ok_q;
  logic [1:0]    s2_bank_q;
  logic [7:0]    s2_pix_q;
  logic [CW-1:0] s2_col_q [2];
  logic [RW-1:0] s2_row_q [2];
  logic          s2_xpar_q, s2_ypar_q, s2_xedge_q, s2_yedge_q, s2_clip_q;
  logic [FB-1:0] s2_wx_q, s2_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (advance) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s2_cmd_q    <= s1_cmd_q;
      s2_ok_q     <= s1_ok_q;
      s2_bank_q   <= {s1_y_q[0], s1_x_q[0]};
      s2_pix_q    <= s1_pix_q;
      s2_col_q[0] <= col_e_d;
      s2_col_q[1] <= col_o_d;
      s2_row_q[0] <= row_e_d;
      s2_row_q[1] <= row_o_d;
      s2_xpar_q   <= x0[0];
      s2_ypar_q   <= y0[0];
      s2_xedge_q  <= idx_x >= 16'(last_x);
      s2_yedge_q  <= idx_y >= 16'(last_y);
      s2_clip_q   <= clip_x || clip_y;
      s2_wx_q     <= s1_px_q[FB-1:0];
      s2_wy_q     <= s1_py_q[FB-1:0];
    end
  end

  // stage 3: banked store, loads write and samples read here in order
  logic       load_we;
  logic [7:0] rd_data [4];

  assign load_we = advance && s2_v_q && (s2_cmd_q == bis_pkg::CMD_LOAD) && s2_ok_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [7:0]    mem [BankD];
    logic [7:0]    rd_q;
    logic [AW-1:0] addr;
    logic          we;

    assign addr = AW'(24'(s2_row_q[b / 2]) * 24'(BankW) + 24'(s2_col_q[b % 2]));
    assign we   = load_we && (s2_bank_q == 2'(b));

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[addr] <= s2_pix_q;
      end
      if (advance) begin
        rd_q <= mem[addr];
      end
    end

    assign rd_data[b] = rd_q;
  end

  logic          s3_v_q;
  logic          s3_xpar_q, s3_ypar_q, s3_xedge_q, s3_yedge_q, s3_clip_q;
  logic [FB-1:0] s3_wx_q, s3_wy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (advance) begin
      s3_v_q <= s2_v_q && (s2_cmd_q == bis_pkg::CMD_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s3_xpar_q  <= s2_xpar_q;
      s3_ypar_q  <= s2_ypar_q;
      s3_xedge_q <= s2_xedge_q;
      s3_yedge_q <= s2_yedge_q;
      s3_clip_q  <= s2_clip_q;
      s3_wx_q    <= s2_wx_q;
      s3_wy_q    <= s2_wy_q;
    end
  end

  // stage 4: route banks to neighbours and interpolate down both columns
  logic [7:0] p00, p10, p01, p11;

  always_comb begin
    p00 = rd_data[{s3_ypar_q, s3_xpar_q}];
    p10 = s3_xedge_q ? p00 : rd_data[{s3_ypar_q, !s3_xpar_q}];
    p01 = s3_yedge_q ? p00 : rd_data[{!s3_ypar_q, s3_xpar_q}];
    if (s3_xedge_q) begin
      p11 = p01;
    end else if (s3_yedge_q) begin
      p11 = p10;
    end else begin
      p11 = rd_data[{!s3_ypar_q, !s3_xpar_q}];
    end
  end

  logic          s4_v_q;
  logic [7:0]    s4_left_q, s4_right_q;
  logic [FB-1:0] s4_wx_q;
  logic          s4_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (advance) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s4_left_q  <= bis_pkg::lerp(p00, p01, s3_wy_q);
      s4_right_q <= bis_pkg::lerp(p10, p11, s3_wy_q);
      s4_wx_q    <= s3_wx_q;
      s4_clip_q  <= s3_clip_q;
    end
  end

  // stage 5: across the row into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.pixel_out <= bis_pkg::lerp(s4_left_q, s4_right_q, s4_wx_q);
      out_data_q.clamped   <= s4_clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
